// ----- hdl/rass_pkg.sv -----
// Shared types and constants for the return address shadow stack.
// Used by rass_shadow_mem and return_address_shadow_stack_core; no dependencies.
`default_nettype none

package rass_pkg;

  // Field widths fixed by the item layout
  localparam int THREAD_IDX_W = 3;
  localparam int DATA_W       = 64;

  // Default sizing of the block
  localparam int DEFAULT_THREADS      = 8;
  localparam int DEFAULT_SHADOW_WORDS = 1024;

  // Stack page and shadow word geometry
  localparam int                PAGE_LOW_BITS = 12;
  localparam logic [DATA_W-1:0] PAGE_BYTES    = 64'h1000;
  localparam int                WORD_SHIFT    = 3;
  localparam logic [DATA_W-1:0] WORD_BYTES    = 64'd8;

  // Result queue depth; it covers every item in flight
  localparam int RESULT_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_END   = 2'd1,
    CMD_CALL  = 2'd2,
    CMD_RET   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_INACTIVE = 2'd1,
    ERR_RANGE    = 2'd2
  } err_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [THREAD_IDX_W-1:0] thread_index;
    logic [DATA_W-1:0]       stack_ptr;
    logic [DATA_W-1:0]       return_value;
  } req_t;

  typedef struct packed {
    logic mismatch;
    logic unaligned;
    err_t error_code;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hdl/rass_shadow_mem.sv -----
// Shadow word memory: one write or read address per cycle, registered read data,
// and a zeroing sweep after reset. Depends on rass_pkg.
`default_nettype none

module rass_shadow_mem #(
  parameter int ADDR_W = 13
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [ADDR_W-1:0]          addr,
  input  wire logic [rass_pkg::DATA_W-1:0] wdata,
  output logic      [rass_pkg::DATA_W-1:0] rdata,
  output logic                            clearing
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [rass_pkg::DATA_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]           clear_addr;

  // Sweep every word to zero after reset, then release
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Single write port shared by the sweep and call pushes
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

  a_no_push_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !wr_en)
    else $error("call push issued during shadow clear sweep");

  a_clear_runs_to_end: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clear_addr) == ADDR_W'(DEPTH - 1))
    else $error("clear sweep ended before last word");

  a_sweep_advances: assert property (@(posedge clk) disable iff (rst)
    clearing && $past(clearing) && !$past(rst) |-> clear_addr == $past(clear_addr) + 1'b1)
    else $error("clear sweep skipped or held a word");

endmodule

`default_nettype wire

// ----- hdl/return_address_shadow_stack_core.sv -----
// Return address shadow stack: per-thread bases in flops, shadow words in one memory,
// two-stage read/compare path and a result queue. Depends on rass_pkg, rass_shadow_mem.
// A result is offered once its request has passed s1, s2 and the result queue.
// Throughput: one request per cycle; the result queue holds every item in flight,
// so requests keep flowing while a result waits, up to RESULT_DEPTH outstanding.
// Reset: bases clear at once; the shadow memory is zeroed by a sweep of
// 2**(thread bits + word bits) words (8192 by default) with req_ready low.
`default_nettype none

module return_address_shadow_stack_core #(
  parameter int THREADS      = rass_pkg::DEFAULT_THREADS,
  parameter int SHADOW_WORDS = rass_pkg::DEFAULT_SHADOW_WORDS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire rass_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output rass_pkg::rsp_t      rsp
);

  localparam int  IDX_SPAN   = 2 ** rass_pkg::THREAD_IDX_W;
  localparam int  BASE_DEPTH = (THREADS < IDX_SPAN) ? THREADS : IDX_SPAN;
  localparam bit  ALL_THREADS = (THREADS >= IDX_SPAN);
  localparam int  TIW        = (BASE_DEPTH > 1) ? $clog2(BASE_DEPTH) : 1;
  localparam int  WIW        = $clog2(SHADOW_WORDS);
  localparam int  ADDR_W     = TIW + WIW;
  localparam longint REGION_BYTES = longint'(SHADOW_WORDS) * 8;
  localparam int  QPW        = $clog2(rass_pkg::RESULT_DEPTH);
  localparam int  QCW        = $clog2(rass_pkg::RESULT_DEPTH + 1);

  typedef struct packed {
    rass_pkg::cmd_t                    cmd;
    logic [rass_pkg::THREAD_IDX_W-1:0] thread_index;
    logic [rass_pkg::DATA_W-1:0]       addr;
    logic [rass_pkg::DATA_W-1:0]       value;
    logic                              unaligned;
  } s1_t;

  typedef struct packed {
    rass_pkg::cmd_t              cmd;
    rass_pkg::err_t              err;
    logic                        unaligned;
    logic [rass_pkg::DATA_W-1:0] value;
  } s2_t;

  logic [rass_pkg::DATA_W-1:0] base [BASE_DEPTH];

  logic s1_valid;
  s1_t  s1;
  logic s2_valid;
  s2_t  s2;

  rass_pkg::rsp_t queue [rass_pkg::RESULT_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic [QCW-1:0] occupancy;

  logic                        clearing;
  logic                        req_xfer;
  logic                        rsp_xfer;
  logic                        thr_ok;
  logic [TIW-1:0]              thr_idx;
  logic [rass_pkg::DATA_W-1:0] base_sel;
  logic [rass_pkg::DATA_W-1:0] offset;
  rass_pkg::err_t              s1_err;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_addr;
  logic [rass_pkg::DATA_W-1:0] mem_rdata;
  rass_pkg::rsp_t              s2_rsp;

  // Admit a request only when the clear sweep is done and the queue can absorb everything in flight
  assign occupancy = count + QCW'(s1_valid) + QCW'(s2_valid);
  assign req_ready = !clearing && (occupancy < QCW'(rass_pkg::RESULT_DEPTH));
  assign req_xfer  = req_valid && req_ready;
  assign rsp_valid = (count != '0);
  assign rsp_xfer  = rsp_valid && rsp_ready;
  assign rsp       = queue[rd_ptr];

  // Capture the request; calls target the word below the stack pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      s1.cmd          <= req.cmd;
      s1.thread_index <= req.thread_index;
      s1.addr         <= (req.cmd == rass_pkg::CMD_CALL) ?
                         req.stack_ptr - rass_pkg::WORD_BYTES : req.stack_ptr;
      s1.value        <= req.return_value;
      s1.unaligned    <= (req.cmd == rass_pkg::CMD_RET) && (req.stack_ptr[2:0] != 3'b000);
    end
  end

  // Locate the shadow word from the thread base
  assign thr_ok   = ALL_THREADS || (32'(s1.thread_index) < THREADS);
  assign thr_idx  = s1.thread_index[TIW-1:0];
  assign base_sel = base[thr_idx];
  assign offset   = base_sel - s1.addr;

  always_comb begin
    if (!thr_ok || (base_sel == '0)) begin
      s1_err = rass_pkg::ERR_INACTIVE;
    end else if (offset >= rass_pkg::DATA_W'(REGION_BYTES)) begin
      s1_err = rass_pkg::ERR_RANGE;
    end else begin
      s1_err = rass_pkg::ERR_OK;
    end
  end

  assign mem_addr = {thr_idx, offset[rass_pkg::WORD_SHIFT +: WIW]};
  assign mem_we   = s1_valid && (s1.cmd == rass_pkg::CMD_CALL) && (s1_err == rass_pkg::ERR_OK);

  // Update thread bases on start and end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BASE_DEPTH; i++) begin
        base[i] <= '0;
      end
    end else if (s1_valid && thr_ok) begin
      unique case (s1.cmd)
        rass_pkg::CMD_START: begin
          base[thr_idx] <= {s1.addr[rass_pkg::DATA_W-1:rass_pkg::PAGE_LOW_BITS],
                            rass_pkg::PAGE_LOW_BITS'(0)} + rass_pkg::PAGE_BYTES;
        end
        rass_pkg::CMD_END: begin
          base[thr_idx] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  rass_shadow_mem #(
    .ADDR_W (ADDR_W)
  ) u_shadow_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (mem_we),
    .addr     (mem_addr),
    .wdata    (s1.value),
    .rdata    (mem_rdata),
    .clearing (clearing)
  );

  // Carry the item alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2.cmd       <= s1.cmd;
      s2.err       <= ((s1.cmd == rass_pkg::CMD_CALL) || (s1.cmd == rass_pkg::CMD_RET)) ?
                      s1_err : rass_pkg::ERR_OK;
      s2.unaligned <= s1.unaligned;
      s2.value     <= s1.value;
    end
  end

  // Compare the stored return address on a clean return
  always_comb begin
    s2_rsp.mismatch   = (s2.cmd == rass_pkg::CMD_RET) && (s2.err == rass_pkg::ERR_OK) &&
                        (mem_rdata != s2.value);
    s2_rsp.unaligned  = s2.unaligned;
    s2_rsp.error_code = s2.err;
  end

  // Result queue: push from the compare stage, pop on output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rsp_xfer) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCW'(s2_valid) - QCW'(rsp_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      queue[wr_ptr] <= s2_rsp;
    end
  end

  a_no_req_during_clear: assert property (@(posedge clk) disable iff (rst)
    req_xfer |-> !clearing)
    else $error("request taken during shadow clear sweep");

  a_queue_never_overflows: assert property (@(posedge clk) disable iff (rst)
    occupancy <= QCW'(rass_pkg::RESULT_DEPTH))
    else $error("items in flight exceed result queue depth");

  a_push_only_on_clean_call: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> s1_valid && (s1.cmd == rass_pkg::CMD_CALL) && thr_ok && (base_sel != '0))
    else $error("shadow write without an active thread call");

  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $past(req_xfer, 2))
    else $error("compare stage valid without a request two cycles earlier");

endmodule

`default_nettype wire

// ----- tb/tb_return_address_shadow_stack_core.sv -----
// Testbench for return_address_shadow_stack_core: directed and random command traffic.
// A predictor tracks thread bases and shadow words and checks every verdict.
// Depends on rass_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_return_address_shadow_stack_core;

  localparam int THREADS       = rass_pkg::DEFAULT_THREADS;
  localparam int SHADOW_WORDS  = rass_pkg::DEFAULT_SHADOW_WORDS;
  localparam int DATA_W        = rass_pkg::DATA_W;
  localparam int THREAD_IDX_W  = rass_pkg::THREAD_IDX_W;
  localparam int WORD_SHIFT    = rass_pkg::WORD_SHIFT;
  localparam int PAGE_LOW_BITS = rass_pkg::PAGE_LOW_BITS;
  localparam logic [DATA_W-1:0] WORD_BYTES   = rass_pkg::WORD_BYTES;
  localparam logic [DATA_W-1:0] PAGE_BYTES   = rass_pkg::PAGE_BYTES;
  localparam logic [DATA_W-1:0] REGION_BYTES = 64'(SHADOW_WORDS) << WORD_SHIFT;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  rass_pkg::req_t req_item = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rass_pkg::rsp_t rsp_item;

  // Transfer bookkeeping
  logic req_taken = 1'b0;
  int   req_accepted = 0;
  int   rsp_seen = 0;
  int   n_items = 0;
  int   error_count = 0;
  int   cycle_count = 0;

  rass_pkg::req_t pending_requests[$];
  rass_pkg::rsp_t expected_verdicts[$];

  // Predictor state
  logic [DATA_W-1:0] model_base [THREADS];
  logic [DATA_W-1:0] model_shadow [THREADS*SHADOW_WORDS];

  // Stimulus generator state: believed base, stack pointer and call stack per thread
  logic [DATA_W-1:0] gen_base [THREADS];
  logic [DATA_W-1:0] gen_sp [THREADS];
  logic [DATA_W-1:0] gen_ret [THREADS][SHADOW_WORDS];
  int                gen_depth [THREADS];

  return_address_shadow_stack_core #(
    .THREADS     (THREADS),
    .SHADOW_WORDS(SHADOW_WORDS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req_item),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp_item)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_failure(input string msg);
    $display("[%0t] check failed: %s", $time, msg);
    error_count++;
  endtask

  // Compute the verdict of one command and apply its effect on the thread state
  task automatic predict_verdict(input rass_pkg::req_t r, output rass_pkg::rsp_t v);
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] off;
    logic [DATA_W-1:0] base;
    logic              thr_ok;
    int                slot;
    v = '0;
    v.error_code = rass_pkg::ERR_OK;
    thr_ok = (int'(r.thread_index) < THREADS);
    base = thr_ok ? model_base[r.thread_index] : '0;
    case (r.cmd)
      rass_pkg::CMD_START: begin
        if (thr_ok)
          model_base[r.thread_index] = {r.stack_ptr[DATA_W-1:PAGE_LOW_BITS],
                                        {PAGE_LOW_BITS{1'b0}}} + PAGE_BYTES;
      end
      rass_pkg::CMD_END: begin
        if (thr_ok) model_base[r.thread_index] = '0;
      end
      default: begin
        // call mirrors the slot below the stack pointer, return the slot at it
        addr = (r.cmd == rass_pkg::CMD_CALL) ? r.stack_ptr - WORD_BYTES : r.stack_ptr;
        if (r.cmd == rass_pkg::CMD_RET) v.unaligned = |r.stack_ptr[WORD_SHIFT-1:0];
        off = base - addr;
        if (base == '0) begin
          v.error_code = rass_pkg::ERR_INACTIVE;
        end else if (off >= REGION_BYTES) begin
          v.error_code = rass_pkg::ERR_RANGE;
        end else begin
          slot = int'(r.thread_index) * SHADOW_WORDS + int'(off >> WORD_SHIFT);
          if (r.cmd == rass_pkg::CMD_CALL) model_shadow[slot] = r.return_value;
          else v.mismatch = (model_shadow[slot] != r.return_value);
        end
      end
    endcase
  endtask

  // Sample both channels; check the oldest verdict, then predict the new one
  always @(posedge clk) begin
    rass_pkg::rsp_t want;
    req_taken <= req_valid && req_ready;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (expected_verdicts.size() == 0) begin
          report_failure($sformatf("unexpected verdict %p", rsp_item));
        end else begin
          want = expected_verdicts.pop_front();
          if (rsp_item.mismatch !== want.mismatch)
            report_failure($sformatf("verdict %0d mismatch got %b want %b",
                                     rsp_seen, rsp_item.mismatch, want.mismatch));
          if (rsp_item.unaligned !== want.unaligned)
            report_failure($sformatf("verdict %0d unaligned got %b want %b",
                                     rsp_seen, rsp_item.unaligned, want.unaligned));
          if (rsp_item.error_code !== want.error_code)
            report_failure($sformatf("verdict %0d error_code got %0d want %0d",
                                     rsp_seen, rsp_item.error_code, want.error_code));
        end
      end
      if (req_valid && req_ready) begin
        predict_verdict(req_item, want);
        expected_verdicts.insert(expected_verdicts.size(), want);
        req_accepted++;
      end
    end
  end

  // Request driver: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        req_item <= pending_requests.pop_front();
        req_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                 : $urandom_range(0, 3);
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Verdict receiver: stall mode is redrawn whenever stall_phase wraps, plus one long hold-off
  int  stall_mode = 0;
  int  stall_phase = 0;
  int  holdoff_left = 0;
  bit  holdoff_done = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (!holdoff_done && rsp_seen >= 400) begin
        holdoff_left = 300;
        holdoff_done = 1'b1;
      end
      stall_phase++;
      if (stall_phase == 64) begin
        stall_phase = 0;
        stall_mode = $urandom_range(0, 2);
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        rsp_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       rsp_ready <= 1'b1;
          1:       rsp_ready <= $urandom_range(0, 1);
          default: rsp_ready <= (stall_phase % 4) != 3;
        endcase
      end
    end
  end

  task automatic add_request(input rass_pkg::cmd_t c, input logic [THREAD_IDX_W-1:0] t,
                             input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] val);
    rass_pkg::req_t r;
    r.cmd          = c;
    r.thread_index = t;
    r.stack_ptr    = sp;
    r.return_value = val;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Start a thread in the generator's view and queue the command
  task automatic gen_start(input int t, input logic [DATA_W-1:0] sp);
    gen_base[t] = {sp[DATA_W-1:PAGE_LOW_BITS], {PAGE_LOW_BITS{1'b0}}} + PAGE_BYTES;
    gen_sp[t] = gen_base[t] - WORD_BYTES * $urandom_range(0, 8);
    if ($urandom_range(0, 9) == 0) gen_sp[t] = gen_sp[t] - $urandom_range(1, 7);
    gen_depth[t] = 0;
    add_request(rass_pkg::CMD_START, THREAD_IDX_W'(t), sp, rand64());
  endtask

  // Mostly balanced call/return walks per thread, with jumps and some noise
  task automatic build_random_traffic(input int count);
    int                          t;
    int                          roll;
    logic [THREAD_IDX_W-1:0]     ti;
    logic [DATA_W-1:0]           sp;
    logic [DATA_W-1:0]           val;
    rass_pkg::cmd_t              c;
    for (int i = 0; i < THREADS; i++) begin
      gen_base[i] = '0;
      gen_depth[i] = 0;
    end
    for (int n = 0; n < count; n++) begin
      t = $urandom_range(0, THREADS - 1);
      ti = THREAD_IDX_W'(t);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // noise: any command, random fields
        c = rass_pkg::cmd_t'($urandom_range(0, 3));
        sp = ($urandom_range(0, 1) == 0 || gen_base[t] == '0) ? rand64()
             : gen_base[t] - 64'($urandom_range(0, 9000)) + 64'd64;
        if (c == rass_pkg::CMD_START) begin
          gen_start(t, sp);
        end else begin
          if (c == rass_pkg::CMD_END) gen_base[t] = '0;
          add_request(c, ti, sp, rand64());
        end
      end else if (gen_base[t] == '0 || roll < 11) begin
        sp = ($urandom_range(0, 19) == 0) ? {52'hfffff_ffff_ffff, 12'($urandom)} : rand64();
        gen_start(t, sp);
      end else if (roll < 13) begin
        gen_base[t] = '0;
        add_request(rass_pkg::CMD_END, ti, rand64(), rand64());
      end else if (roll < 16) begin
        // jump near the far end of the region or above the base
        gen_sp[t] = ($urandom_range(0, 2) == 0)
                    ? gen_base[t] + WORD_BYTES * $urandom_range(0, 3)
                    : gen_base[t] - WORD_BYTES * $urandom_range(1010, 1030);
        gen_depth[t] = 0;
        add_request(rass_pkg::CMD_CALL, ti, gen_sp[t], rand64());
      end else if ((gen_depth[t] > 0 && $urandom_range(0, 99) < 45) ||
                   gen_depth[t] >= SHADOW_WORDS - 1 || $urandom_range(0, 29) == 0) begin
        // return: the matching address, sometimes corrupted
        val = (gen_depth[t] > 0) ? gen_ret[t][gen_depth[t]-1] : rand64();
        if ($urandom_range(0, 9) == 0) val[$urandom_range(0, DATA_W - 1)] ^= 1'b1;
        add_request(rass_pkg::CMD_RET, ti, gen_sp[t], val);
        if (gen_depth[t] > 0) gen_depth[t]--;
        gen_sp[t] = gen_sp[t] + WORD_BYTES;
      end else begin
        val = rand64();
        gen_ret[t][gen_depth[t]] = val;
        gen_depth[t]++;
        add_request(rass_pkg::CMD_CALL, ti, gen_sp[t], val);
        gen_sp[t] = gen_sp[t] - WORD_BYTES;
      end
    end
  endtask

  localparam logic [DATA_W-1:0] BASE0 = 64'h0000_7fff_ffff_f000;
  localparam logic [DATA_W-1:0] ONES  = '1;
  localparam logic [DATA_W-1:0] PAT   = 64'ha5a5_5a5a_c3c3_3c3c;

  initial begin
    for (int i = 0; i < THREADS; i++) model_base[i] = '0;
    for (int i = 0; i < THREADS * SHADOW_WORDS; i++) model_shadow[i] = '0;

    // Directed: inactive threads, region edges, wrap, truncation, restart
    add_request(rass_pkg::CMD_CALL,  3'd3, 64'h1000, ONES);
    add_request(rass_pkg::CMD_RET,   3'd3, 64'h1003, ONES);
    add_request(rass_pkg::CMD_START, 3'd0, 64'h0000_7fff_ffff_e123, '0);
    add_request(rass_pkg::CMD_CALL,  3'd0, BASE0 + 64'd8, ONES);
    add_request(rass_pkg::CMD_CALL,  3'd0, BASE0, '0);
    add_request(rass_pkg::CMD_RET,   3'd0, BASE0 - 64'd8, '0);
    add_request(rass_pkg::CMD_RET,   3'd0, BASE0, ONES);
    add_request(rass_pkg::CMD_RET,   3'd0, BASE0, 64'd1);
    add_request(rass_pkg::CMD_RET,   3'd0, BASE0 + 64'd8, ONES);
    add_request(rass_pkg::CMD_CALL,  3'd0, BASE0 - 64'd8 * 1022, PAT);
    add_request(rass_pkg::CMD_RET,   3'd0, BASE0 - 64'd8 * 1023, PAT);
    add_request(rass_pkg::CMD_CALL,  3'd0, BASE0 - 64'd8 * 1023, PAT);
    add_request(rass_pkg::CMD_RET,   3'd0, BASE0 - 64'd8 * 1024, PAT);
    add_request(rass_pkg::CMD_RET,   3'd0, BASE0 - 64'd8 * 1023 + 64'd5, '0);
    add_request(rass_pkg::CMD_START, 3'd7, 64'hffff_ffff_ffff_f800, ONES);
    add_request(rass_pkg::CMD_CALL,  3'd7, 64'h100, ONES);
    add_request(rass_pkg::CMD_START, 3'd7, '0, '0);
    add_request(rass_pkg::CMD_CALL,  3'd7, 64'h1000, 64'h8000_0000_0000_0000);
    add_request(rass_pkg::CMD_RET,   3'd7, 64'hff8, 64'h8000_0000_0000_0000);
    add_request(rass_pkg::CMD_END,   3'd0, ONES, ONES);
    add_request(rass_pkg::CMD_RET,   3'd0, BASE0 - 64'd8, '0);
    add_request(rass_pkg::CMD_START, 3'd0, BASE0 - 64'd1, ONES);
    add_request(rass_pkg::CMD_RET,   3'd0, BASE0, ONES);
    add_request(rass_pkg::CMD_START, 3'd5, 64'h8000_0000_0000_0000, '0);
    add_request(rass_pkg::CMD_END,   3'd5, ONES, ONES);

    build_random_traffic(RANDOM_ITEMS);
    n_items = pending_requests.size();

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Drain: every request taken, every verdict seen, then let the pipe settle
    while (req_accepted != n_items) @(negedge clk);
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
